>>> rtl/core/wps_pkg.sv
// Package with sizes, register indexes and count clamps for the prefix servability unit.
package wps_pkg;

	localparam int MAX_CHUNKS = 64;
	localparam int MAX_RANKS  = 8;
	localparam int MAX_GROUPS = 4;

	localparam int MASK_W     = 64;
	localparam int RANK_W     = 8;
	localparam int CHUNK_W    = 7;
	localparam int RCOUNT_W   = 4;
	localparam int GCOUNT_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANK_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW0     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW1     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW2     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW3     = 3'd6;

	typedef logic [CHUNK_W-1:0] chunk_t;

	// Clamp a chunk count into 1..MAX_CHUNKS
	function automatic chunk_t clamp_chunks(input chunk_t v);
		chunk_t r;
		if (v == '0) begin
			r = chunk_t'(1);
		end else if (v > chunk_t'(MAX_CHUNKS)) begin
			r = chunk_t'(MAX_CHUNKS);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Clamp a rank count into 1..MAX_RANKS
	function automatic logic [RCOUNT_W-1:0] clamp_ranks(input logic [RCOUNT_W-1:0] v);
		logic [RCOUNT_W-1:0] r;
		if (v == '0) begin
			r = RCOUNT_W'(1);
		end else if (v > RCOUNT_W'(MAX_RANKS)) begin
			r = RCOUNT_W'(MAX_RANKS);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Clamp a group count into 1..MAX_GROUPS
	function automatic logic [GCOUNT_W-1:0] clamp_groups(input logic [GCOUNT_W-1:0] v);
		logic [GCOUNT_W-1:0] r;
		if (v == '0) begin
			r = GCOUNT_W'(1);
		end else if (v > GCOUNT_W'(MAX_GROUPS)) begin
			r = GCOUNT_W'(MAX_GROUPS);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/windowed_prefix_servability_unit.sv
// Top level: per-chunk presence check, run tracking and servable bitmap per pass.
// The last chunk passes through the input register and the result register before its result shows on servable_mask.
// Throughput: one chunk item per cycle while no held result blocks it; the input register, the one-step
//   state update and the result register form a two-stage pipe that advances unless a held result blocks it.
// A held result stalls the input only while the input register is also full.
// Reset (arst_n low): control and configuration registers return to their reset values, state to an empty pass.
module windowed_prefix_servability_unit
	import wps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [RANK_W-1:0]     rank_present,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [MASK_W-1:0]     servable_mask
);

	// Configuration registers
	chunk_t                chunk_count_q;
	logic [RCOUNT_W-1:0]   rank_count_q;
	logic [GCOUNT_W-1:0]   group_count_q;
	chunk_t                window_q [MAX_GROUPS];

	// Pass state
	logic [MASK_W-1:0]     servable_bits_q;
	chunk_t                present_run_q;
	chunk_t                chunk_index_q;
	logic [GCOUNT_W-1:0]   group_index_q;

	// Input and result registers
	logic                  valid_s1;
	logic [RANK_W-1:0]     rank_present_s1;
	logic                  out_valid_q;
	logic [MASK_W-1:0]     servable_mask_q;

	// Combinational update
	chunk_t                cc;
	logic [RCOUNT_W-1:0]   rc;
	logic [GCOUNT_W-1:0]   gc;
	logic [RANK_W-1:0]     rmask;
	logic                  present;
	chunk_t                run_nxt;
	logic [5:0]            ci;
	chunk_t                len;
	chunk_t                win;
	chunk_t                need_win;
	chunk_t                need;
	logic [MASK_W-1:0]     bits_nxt;
	logic [MASK_W-1:0]     cc_mask;
	logic                  group_end;
	logic                  pass_end;
	logic                  blocked;
	logic                  in_xfer;
	logic                  fire;

	assign blocked   = out_valid_q & out_stall;
	assign in_stall  = valid_s1 & blocked;
	assign in_xfer   = in_valid & ~in_stall;
	assign fire      = valid_s1 & ~blocked;
	assign out_valid = out_valid_q;
	assign servable_mask = servable_mask_q;

	// Presence, run and prefix check for the chunk in the input register
	always_comb begin
		cc       = clamp_chunks(chunk_count_q);
		rc       = clamp_ranks(rank_count_q);
		gc       = clamp_groups(group_count_q);
		rmask    = RANK_W'((9'd1 << rc) - 9'd1);
		present  = (rank_present_s1 & rmask) == rmask;
		if (!present) begin
			run_nxt = '0;
		end else if (present_run_q == '1) begin
			run_nxt = present_run_q;
		end else begin
			run_nxt = present_run_q + chunk_t'(1);
		end
		ci       = chunk_index_q[5:0];
		len      = {1'b0, ci} + chunk_t'(1);
		win      = window_q[group_index_q[1:0]];
		need_win = (win == '0) ? cc : win;
		need     = (need_win > len) ? len : need_win;
		bits_nxt = (run_nxt < need) ? (servable_bits_q & ~(64'd1 << ci)) : servable_bits_q;
		cc_mask  = ~64'd0 >> (chunk_t'(MAX_CHUNKS) - cc);
		group_end = ({1'b0, chunk_index_q} + 8'd1) >= {1'b0, cc};
		pass_end  = group_end && (({1'b0, group_index_q} + 4'd1) >= {1'b0, gc});
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_count_q <= chunk_t'(MAX_CHUNKS);
			rank_count_q  <= RCOUNT_W'(MAX_RANKS);
			group_count_q <= GCOUNT_W'(1);
			for (int g = 0; g < MAX_GROUPS; g++) begin
				window_q[g] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHUNK_COUNT: chunk_count_q <= cfg_data;
				REG_RANK_COUNT:  rank_count_q  <= cfg_data[RCOUNT_W-1:0];
				REG_GROUP_COUNT: group_count_q <= cfg_data[GCOUNT_W-1:0];
				REG_WINDOW0:     window_q[0]   <= cfg_data;
				REG_WINDOW1:     window_q[1]   <= cfg_data;
				REG_WINDOW2:     window_q[2]   <= cfg_data;
				REG_WINDOW3:     window_q[3]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the input item until the update stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rank_present_s1 <= rank_present;
		end
	end

	// Advance the pass state by one chunk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servable_bits_q <= '1;
			present_run_q   <= '0;
			chunk_index_q   <= '0;
			group_index_q   <= '0;
		end else if (fire) begin
			if (pass_end) begin
				servable_bits_q <= '1;
				present_run_q   <= '0;
				chunk_index_q   <= '0;
				group_index_q   <= '0;
			end else if (group_end) begin
				servable_bits_q <= bits_nxt;
				present_run_q   <= '0;
				chunk_index_q   <= '0;
				group_index_q   <= group_index_q + GCOUNT_W'(1);
			end else begin
				servable_bits_q <= bits_nxt;
				present_run_q   <= run_nxt;
				chunk_index_q   <= chunk_index_q + chunk_t'(1);
			end
		end
	end

	// Load the result at the end of a pass, drop it after its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && pass_end) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && pass_end) begin
			servable_mask_q <= bits_nxt & cc_mask;
		end
	end

endmodule

>>> rtl/core/wps_checker.sv
// Port-level checker for the prefix servability unit, bound to the top level.
module wps_checker
	import wps_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [MASK_W-1:0]     servable_mask
);

	// Hold a stalled result and its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(servable_mask))
		else $error("stalled result changed or dropped");

	// Stall the input only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	// A new result must trace back to an input transfer through the input and result registers
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a matching input transfer");

	// Clear the result once reset has been applied
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid during reset");

endmodule

bind windowed_prefix_servability_unit wps_checker u_wps_checker (.*);

>>> dv/windowed_prefix_servability_unit_tb.sv
// Self-checking testbench for the windowed prefix servability unit.
`timescale 1ns / 1ps

module windowed_prefix_servability_unit_tb;
	import wps_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 1024;
	localparam int unsigned QUIET_ITEMS   = 150;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned LONG_HOLD     = 80;
	localparam int unsigned PRESSURE_ITEMS = 30;
	localparam int unsigned STALL_LIMIT   = 1000;
	localparam int          DIR_ROWS      = 44;

	typedef enum logic {ROW_WRITE, ROW_CHUNK} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [RANK_W-1:0]     ranks;
		logic                  has_lit;
		logic [MASK_W-1:0]     lit;
	} step_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [RANK_W-1:0]     rank_present = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [MASK_W-1:0]     servable_mask;

	// Predictor copy of the registers
	logic [CHUNK_W-1:0]  cfg_chunks;
	logic [RCOUNT_W-1:0] cfg_ranks;
	logic [GCOUNT_W-1:0] cfg_groups;
	logic [CHUNK_W-1:0]  cfg_window [MAX_GROUPS];

	// Predictor copy of the pass state
	logic [MASK_W-1:0]   serv_bits;
	logic [CHUNK_W-1:0]  run_len;
	logic [CHUNK_W-1:0]  chunk_pos;
	logic [GCOUNT_W-1:0] group_pos;

	logic [MASK_W-1:0] pending_masks [$];

	int unsigned items_sent = 0;
	int unsigned masks_seen = 0;
	int unsigned reg_writes = 0;
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	bit          quiet = 1'b0;
	bit          no_gaps = 1'b0;
	bit          hold_request = 1'b0;
	bit          hold_done = 1'b0;

	step_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_WRITE, REG_CHUNK_COUNT, 7'd1,   8'h00, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b1, 64'h1},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'h7F, 1'b1, 64'h0},
		'{ROW_WRITE, REG_RANK_COUNT,  7'd0,   8'h00, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'h01, 1'b1, 64'h1},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFE, 1'b1, 64'h0},
		'{ROW_WRITE, REG_RANK_COUNT,  7'h7F,  8'h00, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b1, 64'h1},
		'{ROW_WRITE, REG_CHUNK_COUNT, 7'd0,   8'h00, 1'b0, 64'h0},
		'{ROW_WRITE, REG_GROUP_COUNT, 7'd0,   8'h00, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b1, 64'h1},
		'{ROW_WRITE, REG_RANK_COUNT,  7'd8,   8'h00, 1'b0, 64'h0},
		'{ROW_WRITE, REG_CHUNK_COUNT, 7'd4,   8'h00, 1'b0, 64'h0},
		'{ROW_WRITE, REG_GROUP_COUNT, 7'd2,   8'h00, 1'b0, 64'h0},
		'{ROW_WRITE, REG_WINDOW1,     7'd2,   8'h00, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'h00, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'h00, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		'{ROW_WRITE, REG_GROUP_COUNT, 7'd7,   8'h00, 1'b0, 64'h0},
		'{ROW_WRITE, REG_CHUNK_COUNT, 7'd2,   8'h00, 1'b0, 64'h0},
		'{ROW_WRITE, REG_WINDOW0,     7'd1,   8'h00, 1'b0, 64'h0},
		'{ROW_WRITE, REG_WINDOW1,     7'd64,  8'h00, 1'b0, 64'h0},
		'{ROW_WRITE, REG_WINDOW2,     7'h7F,  8'h00, 1'b0, 64'h0},
		'{ROW_WRITE, REG_WINDOW3,     7'd1,   8'h00, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'h00, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'h00, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'h80, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		// start a new pass, then shrink the chunk count in the middle of it
		'{ROW_WRITE, REG_CHUNK_COUNT, 7'd4,   8'h00, 1'b0, 64'h0},
		'{ROW_WRITE, REG_GROUP_COUNT, 7'd1,   8'h00, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0},
		'{ROW_WRITE, REG_CHUNK_COUNT, 7'd2,   8'h00, 1'b0, 64'h0},
		'{ROW_CHUNK, REG_CHUNK_COUNT, 7'd0,   8'hFF, 1'b0, 64'h0}
	};

	windowed_prefix_servability_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rank_present (rank_present),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.servable_mask(servable_mask)
	);

	always #5 clk = ~clk;

	// Clamp a count register into 1..hi
	function automatic int unsigned bound_count(input int unsigned v, input int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Ranks that must all hold a chunk for it to count as present
	function automatic logic [RANK_W-1:0] ranks_in_use();
		int unsigned rc;
		rc = bound_count(cfg_ranks, MAX_RANKS);
		return (rc >= RANK_W) ? '1 : RANK_W'((1 << rc) - 1);
	endfunction

	function automatic void clear_pass();
		serv_bits = '1;
		run_len   = '0;
		chunk_pos = '0;
		group_pos = '0;
	endfunction

	// Fold one chunk into the pass state; return 1 with the mask when the pass closes
	function automatic bit fold_chunk(input logic [RANK_W-1:0] ranks,
			output logic [MASK_W-1:0] mask);
		int unsigned cc, gc, pos, need, win;
		logic [RANK_W-1:0] need_ranks;
		cc = bound_count(cfg_chunks, MAX_CHUNKS);
		gc = bound_count(cfg_groups, MAX_GROUPS);
		need_ranks = ranks_in_use();
		pos = chunk_pos[5:0];
		win = cfg_window[group_pos[1:0]];
		mask = '0;

		// extend or break the present run
		if ((ranks & need_ranks) == need_ranks) begin
			if (run_len != '1)
				run_len = run_len + 1'b1;
		end else begin
			run_len = '0;
		end

		need = (win == 0) ? cc : win;
		if (need > pos + 1)
			need = pos + 1;
		if (run_len < need)
			serv_bits[pos] = 1'b0;

		// advance chunk, group and pass
		if (int'(chunk_pos) + 1 >= cc) begin
			chunk_pos = '0;
			run_len   = '0;
			if (int'(group_pos) + 1 >= gc) begin
				mask = serv_bits & ((cc >= MASK_W) ? '1 : ((64'd1 << cc) - 64'd1));
				clear_pass();
				return 1'b1;
			end
			group_pos = group_pos + 1'b1;
		end else begin
			chunk_pos = chunk_pos + 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic flag_mismatch(input string what, input logic [MASK_W-1:0] got,
			input logic [MASK_W-1:0] want);
		$display("MISMATCH at %0t: %s: got %h, want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Check results at the rising edge; watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			masks_seen++;
			if (pending_masks.size() == 0)
				flag_mismatch("servable_mask with nothing pending", servable_mask, '0);
			else if (servable_mask !== pending_masks[0])
				flag_mismatch("servable_mask", servable_mask, pending_masks.pop_front());
			else
				void'(pending_masks.pop_front());
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d masks pending",
				STALL_LIMIT, pending_masks.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold on request
	initial begin : receiver
		int unsigned n;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(3) == 0) begin
				n = $urandom_range(1, 15);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic idle_sender(input int unsigned n);
		@(negedge clk);
		in_valid <= 1'b0;
		rank_present <= RANK_W'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	// Offer one chunk, hold it until transfer, then predict
	task automatic send_chunk(input logic [RANK_W-1:0] ranks, input bit has_lit,
			input logic [MASK_W-1:0] lit);
		logic [MASK_W-1:0] m;
		if (!no_gaps && $urandom_range(4) == 0)
			idle_sender($urandom_range(1, 15));
		@(negedge clk);
		in_valid <= 1'b1;
		rank_present <= ranks;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (fold_chunk(ranks, m))
			pending_masks.push_back(has_lit ? lit : m);
	endtask

	// Drop valid, wait for every pending mask, then let the pipe empty
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_masks.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			REG_CHUNK_COUNT: cfg_chunks = data;
			REG_RANK_COUNT:  cfg_ranks = data[RCOUNT_W-1:0];
			REG_GROUP_COUNT: cfg_groups = data[GCOUNT_W-1:0];
			REG_WINDOW0:     cfg_window[0] = data;
			REG_WINDOW1:     cfg_window[1] = data;
			REG_WINDOW2:     cfg_window[2] = data;
			REG_WINDOW3:     cfg_window[3] = data;
			default: ;
		endcase
	endtask

	// Present chunks hit_pct percent of the time; absent ones drop a single rank in use, some are noise
	function automatic logic [RANK_W-1:0] make_ranks(input int unsigned hit_pct);
		logic [RANK_W-1:0] need, r;
		int unsigned rc;
		rc = bound_count(cfg_ranks, MAX_RANKS);
		need = ranks_in_use();
		r = RANK_W'($urandom);
		if ($urandom_range(99) < hit_pct)
			r = r | need;
		else if ($urandom_range(3) != 0)
			r = (r | need) & ~(RANK_W'(1) << $urandom_range(rc - 1));
		return r;
	endfunction

	// Pick a random setting, small counts most of the time
	task automatic pick_config();
		logic [CHUNK_W-1:0] cc;
		logic [RCOUNT_W-1:0] rc;
		logic [GCOUNT_W-1:0] gc;
		logic [CHUNK_W-1:0] w;
		int unsigned cc_eff;
		case ($urandom_range(9))
			0: cc = '0;
			1: cc = CHUNK_W'($urandom_range(MAX_CHUNKS + 1, 127));
			2: cc = CHUNK_W'(MAX_CHUNKS);
			3: cc = CHUNK_W'($urandom_range(9, MAX_CHUNKS - 1));
			default: cc = CHUNK_W'($urandom_range(1, 8));
		endcase
		cc_eff = bound_count(cc, MAX_CHUNKS);
		rc = ($urandom_range(3) == 0) ? RCOUNT_W'($urandom) : RCOUNT_W'($urandom_range(1, 8));
		gc = ($urandom_range(4) == 0) ? GCOUNT_W'($urandom) : GCOUNT_W'($urandom_range(1, 4));
		write_reg(REG_CHUNK_COUNT, cc);
		write_reg(REG_RANK_COUNT, {3'($urandom), rc});
		write_reg(REG_GROUP_COUNT, {4'($urandom), gc});
		for (int g = 0; g < MAX_GROUPS; g++) begin
			case ($urandom_range(5))
				0, 1: w = '0;
				2: w = CHUNK_W'($urandom);
				default: w = CHUNK_W'($urandom_range(1, cc_eff));
			endcase
			write_reg(REG_WINDOW0 + CFG_IDX_W'(g), w);
		end
	endtask

	initial begin : stimulus
		int unsigned rand_items, pass_len, passes, hit_pct, n;
		cfg_chunks = CHUNK_W'(MAX_CHUNKS);
		cfg_ranks  = RCOUNT_W'(MAX_RANKS);
		cfg_groups = GCOUNT_W'(1);
		for (int g = 0; g < MAX_GROUPS; g++)
			cfg_window[g] = '0;
		clear_pass();
		rand_items = 0;

		// hold reset, release on a falling edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				settle_block();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_chunk(dir_rows[i].ranks, dir_rows[i].has_lit, dir_rows[i].lit);
			end
		end

		// fill the block behind a long output hold
		settle_block();
		write_reg(REG_CHUNK_COUNT, 7'd1);
		write_reg(REG_GROUP_COUNT, 7'd1);
		no_gaps = 1'b1;
		hold_request = 1'b1;
		for (int i = 0; i < PRESSURE_ITEMS; i++)
			send_chunk(make_ranks(50), 1'b0, '0);
		hold_request = 1'b0;
		no_gaps = 1'b0;

		// random phases of whole passes, some left open across a setting change
		while (rand_items < RANDOM_ITEMS) begin
			settle_block();
			pick_config();
			pass_len = bound_count(cfg_chunks, MAX_CHUNKS) * bound_count(cfg_groups, MAX_GROUPS);
			passes = (pass_len > 64) ? 1 : $urandom_range(1, 6);
			case ($urandom_range(2))
				0: hit_pct = 50;
				1: hit_pct = 85;
				default: hit_pct = 97;
			endcase
			for (int p = 0; p < passes; p++) begin
				for (int k = 0; k < pass_len; k++) begin
					send_chunk(make_ranks(hit_pct), 1'b0, '0);
					rand_items++;
				end
				if (!no_gaps && $urandom_range(7) == 0)
					settle_block();
			end
			if ($urandom_range(4) == 0) begin
				n = $urandom_range(1, pass_len);
				for (int k = 0; k < n; k++) begin
					send_chunk(make_ranks(hit_pct), 1'b0, '0);
					rand_items++;
				end
			end
			if (rand_items + QUIET_ITEMS >= RANDOM_ITEMS) begin
				quiet = 1'b1;
				no_gaps = 1'b1;
			end
		end

		settle_block();
		$display("Ran %0d chunk transfers, %0d servable masks, %0d register writes",
			items_sent, masks_seen, reg_writes);
		$display("Covered clamped counts, wide windows, mid-pass changes and a long output hold");
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> windowed_prefix_servability_unit.f
rtl/core/wps_pkg.sv
rtl/core/windowed_prefix_servability_unit.sv
rtl/core/wps_checker.sv
dv/windowed_prefix_servability_unit_tb.sv
